### rtl/ccdp_pkg.sv
// Shared types, byte codes and directive key table for the Cache-Control parser.
// No dependencies; used by every module in the rtl folder except ccdp_fifo.
package ccdp_pkg;

  localparam int NumKeys  = 9;
  localparam int NumFlags = 7;
  localparam int NumAges  = 2;
  localparam int KeyMaxAge = 7;

  localparam int DefaultInDepth  = 4;
  localparam int DefaultOutDepth = 2;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  // Largest magnitude a value may reach; one beyond it is an overflow.
  localparam logic [31:0] MagLimit = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_byte;
    logic       is_comma;
    logic       is_ws;
    logic       is_eq;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_plus;
    logic       is_minus;
  } byte_class_t;

  typedef struct packed {
    logic [NumFlags-1:0] flags;
    logic signed [31:0]  max_age;
    logic signed [31:0]  shared_max_age;
    logic                parse_error;
  } result_t;

  // Directive keys, right-aligned: character p of a key of length n sits at byte n-1-p.
  function automatic logic [127:0] key_text(input int unsigned k);
    case (k)
      0:       return 128'("must-revalidate");
      1:       return 128'("no-cache");
      2:       return 128'("no-store");
      3:       return 128'("no-transform");
      4:       return 128'("public");
      5:       return 128'("private");
      6:       return 128'("proxy-revalidate");
      7:       return 128'("max-age");
      8:       return 128'("s-maxage");
      default: return '0;
    endcase
  endfunction

  function automatic logic [4:0] key_len(input int unsigned k);
    case (k)
      0:       return 5'd15;
      1:       return 5'd8;
      2:       return 5'd8;
      3:       return 5'd12;
      4:       return 5'd6;
      5:       return 5'd7;
      6:       return 5'd16;
      7:       return 5'd7;
      8:       return 5'd8;
      default: return 5'd0;
    endcase
  endfunction

  // Character of key k at position pos; only meaningful while pos is below the key length.
  function automatic logic [7:0] key_byte(input int unsigned k, input logic [3:0] pos);
    logic [127:0] txt;
    logic [3:0]   idx;
    txt = key_text(k);
    idx = 4'(key_len(k) - 5'd1 - {1'b0, pos});
    return txt[{idx, 3'b000} +: 8];
  endfunction

endpackage

### rtl/cache_control_directive_parser.sv
// Cache-Control header parser. Takes one byte of the header value per cycle through a
// queue-style port and returns one result transaction for each byte marked final. Bytes
// are classified on entry and queued; the parser behind the queue handles one byte per
// cycle, so the sustained rate is one byte per cycle, and the result of a final byte
// becomes visible on the result side in the cycle after that byte is taken. The parser
// stalls only while the result queue is full, and the input then reports full once its
// byte queue has filled. Depends on ccdp_pkg, ccdp_front, ccdp_back and ccdp_fifo.
module cache_control_directive_parser #(
  parameter int InDepth  = ccdp_pkg::DefaultInDepth,
  parameter int OutDepth = ccdp_pkg::DefaultOutDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_byte_i,
  input  logic               final_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               must_revalidate_o,
  output logic               no_cache_o,
  output logic               no_store_o,
  output logic               no_transform_o,
  output logic               is_public_o,
  output logic               is_private_o,
  output logic               proxy_revalidate_o,
  output logic signed [31:0] max_age_o,
  output logic signed [31:0] shared_max_age_o,
  output logic               parse_error_o
);
  import ccdp_pkg::*;

  byte_class_t                cls;
  logic                       cls_empty, cls_pop;
  result_t                    res_in, res_out;
  logic                       res_push, res_full;
  logic [$bits(result_t)-1:0] res_data;

  ccdp_front #(
    .Depth(InDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .char_byte_i (char_byte_i),
    .final_byte_i(final_byte_i),
    .pop_i       (cls_pop),
    .empty_o     (cls_empty),
    .class_o     (cls)
  );

  ccdp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_empty_i(cls_empty),
    .in_class_i(cls),
    .in_pop_o  (cls_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_in)
  );

  ccdp_fifo #(
    .Width($bits(result_t)),
    .Depth(OutDepth)
  ) u_result_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (res_full),
    .data_i (res_in),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_data)
  );

  assign res_out            = result_t'(res_data);
  assign must_revalidate_o  = res_out.flags[0];
  assign no_cache_o         = res_out.flags[1];
  assign no_store_o         = res_out.flags[2];
  assign no_transform_o     = res_out.flags[3];
  assign is_public_o        = res_out.flags[4];
  assign is_private_o       = res_out.flags[5];
  assign proxy_revalidate_o = res_out.flags[6];
  assign max_age_o          = res_out.max_age;
  assign shared_max_age_o   = res_out.shared_max_age;
  assign parse_error_o      = res_out.parse_error;

endmodule

### rtl/ccdp_fifo.sv
// Small first-in first-out queue of flip-flops with full and empty flags.
// Standalone; used between the front and back parts and on the result side.
module ccdp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

### rtl/ccdp_front.sv
// Front part: accepts header bytes, classifies each one and queues it for the parser.
// Depends on ccdp_pkg and ccdp_fifo.
module ccdp_front #(
  parameter int Depth = ccdp_pkg::DefaultInDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            char_byte_i,
  input  logic                  final_byte_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output ccdp_pkg::byte_class_t class_o
);
  import ccdp_pkg::*;

  byte_class_t cls;
  logic [$bits(byte_class_t)-1:0] q_data;

  always_comb begin
    cls            = '0;
    cls.char_byte  = char_byte_i;
    cls.final_byte = final_byte_i;
    cls.is_comma   = (char_byte_i == CharComma);
    cls.is_ws      = (char_byte_i == CharSpace) ||
                     ((char_byte_i >= CharTab) && (char_byte_i <= CharCr));
    cls.is_eq      = (char_byte_i == CharEq);
    cls.is_digit   = (char_byte_i >= CharZero) && (char_byte_i <= CharNine);
    cls.digit      = 4'(char_byte_i - CharZero);
    cls.is_plus    = (char_byte_i == CharPlus);
    cls.is_minus   = (char_byte_i == CharMinus);
  end

  ccdp_fifo #(
    .Width($bits(byte_class_t)),
    .Depth(Depth)
  ) u_byte_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .full_o (full_o),
    .data_i (cls),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .data_o (q_data)
  );

  assign class_o = byte_class_t'(q_data);

endmodule

### rtl/ccdp_back.sv
// Back part: walks the classified bytes, matches directive keys, accumulates age values
// and builds one result on the final byte. Depends on ccdp_pkg.
module ccdp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_empty_i,
  input  ccdp_pkg::byte_class_t in_class_i,
  output logic                  in_pop_o,
  input  logic                  res_full_i,
  output logic                  res_push_o,
  output ccdp_pkg::result_t     res_o
);
  import ccdp_pkg::*;

  typedef enum logic [1:0] {
    PhaseKey   = 2'd0,
    PhaseEq    = 2'd1,
    PhaseValue = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [NumKeys-1:0]  kmv_q, kmv_d;
  logic [4:0]          kpos_q, kpos_d;
  logic                vneg_q, vneg_d, vdig_q, vdig_d, vstop_q, vstop_d, vovf_q, vovf_d;
  logic [31:0]         mag_q, mag_d;
  logic [NumFlags-1:0] flags_q, flags_d;
  logic [NumAges-1:0]  err_q, err_d;
  logic [31:0]         val_q [NumAges];
  logic [31:0]         val_d [NumAges];

  logic        take, first, age_err, any_err;
  logic [35:0] mag_next;
  byte_class_t b;

  assign b        = in_class_i;
  assign take     = !in_empty_i && !res_full_i;
  assign in_pop_o = take;
  assign mag_next = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {32'd0, b.digit};

  always_comb begin
    phase_d    = phase_q;
    kmv_d      = kmv_q;
    kpos_d     = kpos_q;
    vneg_d     = vneg_q;
    vdig_d     = vdig_q;
    vstop_d    = vstop_q;
    vovf_d     = vovf_q;
    mag_d      = mag_q;
    flags_d    = flags_q;
    err_d      = err_q;
    val_d      = val_q;
    first      = 1'b0;
    age_err    = 1'b0;
    any_err    = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;

    if (take) begin
      if (b.is_comma || b.is_ws) begin
        // Commas only close the token below; whitespace is dropped.
      end else if (phase_q == PhaseKey) begin
        if (b.is_eq) begin
          phase_d = PhaseEq;
        end else begin
          for (int k = 0; k < NumKeys; k++) begin
            if ((kpos_q >= key_len(k)) || (key_byte(k, kpos_q[3:0]) != b.char_byte)) begin
              kmv_d[k] = 1'b0;
            end
          end
          if (kpos_q != 5'd31) begin
            kpos_d = kpos_q + 5'd1;
          end
        end
      end else begin
        first   = (phase_q == PhaseEq);
        phase_d = PhaseValue;
        if (!vstop_q) begin
          if (b.is_digit) begin
            if (mag_next > {4'd0, MagLimit}) begin
              mag_d  = MagLimit;
              vovf_d = 1'b1;
            end else begin
              mag_d = mag_next[31:0];
            end
            vdig_d = 1'b1;
          end else if (first && (b.is_plus || b.is_minus)) begin
            vneg_d = vneg_q | b.is_minus;
          end else begin
            vstop_d = 1'b1;
          end
        end
      end

      // Close the token. A key followed by '=' and nothing else matches no directive.
      if (b.is_comma || b.final_byte) begin
        if (phase_d != PhaseEq) begin
          for (int k = 0; k < NumFlags; k++) begin
            if (kmv_d[k] && (kpos_d == key_len(k))) begin
              flags_d[k] = 1'b1;
            end
          end
          for (int j = 0; j < NumAges; j++) begin
            if (kmv_d[KeyMaxAge + j] && (kpos_d == key_len(KeyMaxAge + j))) begin
              if (phase_d == PhaseKey) begin
                err_d[j] = 1'b1;
                val_d[j] = '0;
              end else begin
                age_err  = !vdig_d || vovf_d || (!vneg_d && mag_d[31]);
                err_d[j] = age_err;
                val_d[j] = age_err ? 32'd0 : (vneg_d ? 32'd0 - mag_d : mag_d);
              end
            end
          end
        end
        phase_d = PhaseKey;
        kmv_d   = '1;
        kpos_d  = '0;
        vneg_d  = 1'b0;
        vdig_d  = 1'b0;
        vstop_d = 1'b0;
        vovf_d  = 1'b0;
        mag_d   = '0;
      end

      if (b.final_byte) begin
        any_err              = |err_d;
        res_push_o           = 1'b1;
        res_o.flags          = flags_d;
        res_o.max_age        = any_err ? 32'sd0 : signed'(val_d[0]);
        res_o.shared_max_age = any_err ? 32'sd0 : signed'(val_d[1]);
        res_o.parse_error    = any_err;
        flags_d              = '0;
        err_d                = '0;
        for (int j = 0; j < NumAges; j++) begin
          val_d[j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseKey;
      kmv_q   <= '1;
      kpos_q  <= '0;
      vneg_q  <= 1'b0;
      vdig_q  <= 1'b0;
      vstop_q <= 1'b0;
      vovf_q  <= 1'b0;
      mag_q   <= '0;
      flags_q <= '0;
      err_q   <= '0;
      for (int j = 0; j < NumAges; j++) begin
        val_q[j] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      kmv_q   <= kmv_d;
      kpos_q  <= kpos_d;
      vneg_q  <= vneg_d;
      vdig_q  <= vdig_d;
      vstop_q <= vstop_d;
      vovf_q  <= vovf_d;
      mag_q   <= mag_d;
      flags_q <= flags_d;
      err_q   <= err_d;
      val_q   <= val_d;
    end
  end

endmodule
